### hdl/mpra_pkg.sv
package mpra_pkg;

  localparam int SAMPLES_PER_BLOCK = 64;
  localparam int SAMPLES_PER_MB    = 384;
  localparam int POS_W             = 9;
  localparam int BLOCK_W           = 3;
  localparam int SAMPLE_W          = 16;
  localparam int PIXEL_W           = 8;
  localparam int MODE_W            = 3;
  localparam int CBP_W             = 6;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [1:0] PRED_FWD = 2'd0;
  localparam logic [1:0] PRED_BWD = 2'd1;
  localparam logic [1:0] PRED_AVG = 2'd2;

  typedef struct packed {
    logic [PIXEL_W-1:0]  fwd;
    logic [PIXEL_W-1:0]  bwd;
    logic [SAMPLE_W-1:0] res;
    logic [1:0]          pred_sel;
    logic                use_res;
    logic                invalid;
    logic                last;
  } op_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                invalid;
  } result_t;

endpackage

### hdl/mpra_queue.sv
module mpra_queue #(
  parameter type ITEM_T = logic,
  parameter int  DEPTH  = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  ITEM_T item_in,
  output logic  full,
  input  logic  pop,
  output ITEM_T item_out,
  output logic  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ITEM_T          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign item_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

### hdl/mpra_front.sv
module mpra_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [mpra_pkg::PIXEL_W-1:0]  in_forward_pixel,
  input  logic [mpra_pkg::PIXEL_W-1:0]  in_backward_pixel,
  input  logic [mpra_pkg::SAMPLE_W-1:0] in_residual,
  input  logic [mpra_pkg::MODE_W-1:0]   in_mode,
  input  logic [mpra_pkg::CBP_W-1:0]    in_coded_pattern,
  input  logic                          op_full,
  output logic                          op_push,
  output mpra_pkg::op_t                 op
);
  import mpra_pkg::*;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [BLOCK_W-1:0] block;
  logic               coded;
  logic               last;

  assign op_push = in_push && !op_full;

  // Block index is the position divided by the block size.
  assign block = pos_r[POS_W-1 -: BLOCK_W];
  assign last  = (pos_r == POS_W'(SAMPLES_PER_MB - 1));

  always_comb begin
    unique case (block)
      3'd0:    coded = in_coded_pattern[5];
      3'd1:    coded = in_coded_pattern[4];
      3'd2:    coded = in_coded_pattern[3];
      3'd3:    coded = in_coded_pattern[2];
      3'd4:    coded = in_coded_pattern[1];
      3'd5:    coded = in_coded_pattern[0];
      default: coded = 1'b0;
    endcase
  end

  always_comb begin
    op.fwd     = in_forward_pixel;
    op.bwd     = in_backward_pixel;
    op.res     = in_residual;
    op.invalid = (in_mode == '0);
    op.use_res = in_mode[0] && coded;
    op.last    = last;
    case (in_mode[2:1])
      2'b11:   op.pred_sel = PRED_AVG;
      2'b10:   op.pred_sel = PRED_BWD;
      default: op.pred_sel = PRED_FWD;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    if (op_push) begin
      pos_nxt = last ? '0 : pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

### hdl/mpra_back.sv
module mpra_back #(
  parameter int QDEPTH = mpra_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mpra_pkg::op_t     op,
  input  logic              op_empty,
  output logic              op_pop,
  input  logic              res_pop,
  output mpra_pkg::result_t res,
  output logic              res_empty
);
  import mpra_pkg::*;

  logic                res_full;
  logic [PIXEL_W:0]    avg_sum;
  logic [PIXEL_W-1:0]  pred;
  logic [SAMPLE_W-1:0] addend;
  result_t             res_calc;

  assign op_pop = !op_empty && !res_full;

  assign avg_sum = {1'b0, op.fwd} + {1'b0, op.bwd} + (PIXEL_W+1)'(1);

  always_comb begin
    unique case (op.pred_sel)
      PRED_AVG: pred = avg_sum[PIXEL_W:1];
      PRED_BWD: pred = op.bwd;
      default:  pred = op.fwd;
    endcase
  end

  assign addend = op.use_res ? op.res : '0;

  always_comb begin
    res_calc.last    = op.last;
    res_calc.invalid = op.invalid;
    // The sum wraps to 16 bits; an invalid mode reads as zero.
    res_calc.sample  = op.invalid ? '0 : {{(SAMPLE_W-PIXEL_W){1'b0}}, pred} + addend;
  end

  mpra_queue #(
    .ITEM_T (result_t),
    .DEPTH  (QDEPTH)
  ) u_res_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (op_pop),
    .item_in  (res_calc),
    .full     (res_full),
    .pop      (res_pop),
    .item_out (res),
    .empty    (res_empty)
  );

endmodule

### hdl/macroblock_prediction_residual_add_top.sv
// A transaction is held in the op queue, then its result in the result queue.
// Throughput: one sample per cycle unless stalled; the back-end add is combinational.
// Two small queues (front to back, back to output) let each side stall on its own.
// Reset (synchronous, active low) empties both queues and returns the position
// counter to the first sample of a macroblock.
module macroblock_prediction_residual_add_top #(
  parameter int QDEPTH = mpra_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [mpra_pkg::PIXEL_W-1:0]         in_forward_pixel,
  input  logic [mpra_pkg::PIXEL_W-1:0]         in_backward_pixel,
  input  logic signed [mpra_pkg::SAMPLE_W-1:0] in_residual,
  input  logic [mpra_pkg::MODE_W-1:0]          in_mode,
  input  logic [mpra_pkg::CBP_W-1:0]           in_coded_pattern,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [mpra_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                 out_last_sample,
  output logic                                 out_invalid_mode
);
  import mpra_pkg::*;

  op_t     op_in, op_out;
  logic    op_push, op_full, op_pop, op_empty;
  result_t res;

  mpra_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_forward_pixel  (in_forward_pixel),
    .in_backward_pixel (in_backward_pixel),
    .in_residual       (in_residual),
    .in_mode           (in_mode),
    .in_coded_pattern  (in_coded_pattern),
    .op_full           (op_full),
    .op_push           (op_push),
    .op                (op_in)
  );

  mpra_queue #(
    .ITEM_T (op_t),
    .DEPTH  (QDEPTH)
  ) u_op_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (op_push),
    .item_in  (op_in),
    .full     (op_full),
    .pop      (op_pop),
    .item_out (op_out),
    .empty    (op_empty)
  );

  mpra_back #(
    .QDEPTH (QDEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op_out),
    .op_empty  (op_empty),
    .op_pop    (op_pop),
    .res_pop   (out_pop),
    .res       (res),
    .res_empty (out_empty)
  );

  assign in_full          = op_full;
  assign out_sample_out   = res.sample;
  assign out_last_sample  = res.last;
  assign out_invalid_mode = res.invalid;

endmodule
